// ----- hdl/virtual_time_event_queue_defines.svh -----
// Assertion macros shared by the virtual time event queue RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef VIRTUAL_TIME_EVENT_QUEUE_DEFINES_SVH
`define VIRTUAL_TIME_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define VTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/vtq_pkg.sv -----
// Shared types and constants for the virtual time event queue.
// Used by vtq_cell and virtual_time_event_queue; depends on nothing.
package vtq_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_W  = 48;
  localparam int LATE_W  = 32;
  localparam int SPEED_W = 16;

  // Default configuration of the queue.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  // Reset value of the speed factor, 1.0 in 8.8 fixed point.
  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;

  // Largest virtual time.
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Input opcodes.
  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_TICK    = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_SETTIME = 3'd4
  } op_t;

  // Result status codes.
  localparam logic STATUS_DUE  = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_REM,
    CMD_POP,
    CMD_SETT
  } cell_cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_SETT,
    ST_TADD,
    ST_POP,
    ST_DROP
  } state_t;

  // Broadcast control word for the chain.
  typedef struct packed {
    cell_cmd_t         cmd;
    logic [TIME_W-1:0] new_dl;  // deadline of the entry being inserted
    logic [TIME_W-1:0] vt;      // current virtual time
    logic [TIME_W:0]   diff;    // signed shift applied to every deadline
  } cell_ctl_t;

  // State one cell shows its neighbors.
  typedef struct packed {
    logic              valid;
    logic              cond;    // new deadline goes at or before this slot
    logic [TIME_W-1:0] dl;
  } cell_link_t;

endpackage

// ----- hdl/vtq_cell.sv -----
// One slot of the sorted timer chain: holds a deadline, an id and a valid bit.
// Depends on vtq_pkg and on virtual_time_event_queue_defines.svh for nothing.
module vtq_cell #(
  parameter int ID_BITS = vtq_pkg::DEF_ID_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtq_pkg::cell_ctl_t   ctl,
  input  logic [ID_BITS-1:0]   cmd_id,
  input  vtq_pkg::cell_link_t  left,
  input  logic [ID_BITS-1:0]   left_id,
  input  vtq_pkg::cell_link_t  right,
  input  logic [ID_BITS-1:0]   right_id,
  input  logic                 found_in,
  output vtq_pkg::cell_link_t  self,
  output logic [ID_BITS-1:0]   self_id,
  output logic                 found_out,
  output logic                 due
);

  logic                       valid_r, valid_nxt;
  logic [vtq_pkg::TIME_W-1:0] dl_r, dl_nxt;
  logic [ID_BITS-1:0]         id_r, id_nxt;
  logic                       cond;
  logic                       match;
  logic [vtq_pkg::TIME_W+1:0] shifted;
  logic [vtq_pkg::TIME_W-1:0] shifted_sat;

  // Insert position found in each cell; remove match rippled along the chain.
  assign cond      = !valid_r || (ctl.new_dl < dl_r);
  assign match     = valid_r && (id_r == cmd_id);
  assign found_out = found_in || match;
  assign due       = valid_r && (dl_r <= ctl.vt);

  assign self.valid = valid_r;
  assign self.cond  = cond;
  assign self.dl    = dl_r;
  assign self_id    = id_r;

  // Deadline shifted by the set-time offset, clamped to the time range.
  assign shifted = $signed({2'b00, dl_r}) + $signed({ctl.diff[vtq_pkg::TIME_W], ctl.diff});
  always_comb begin
    if (shifted[vtq_pkg::TIME_W+1]) begin
      shifted_sat = '0;
    end else if (shifted[vtq_pkg::TIME_W]) begin
      shifted_sat = vtq_pkg::TIME_MAX;
    end else begin
      shifted_sat = shifted[vtq_pkg::TIME_W-1:0];
    end
  end

  // Next slot contents for each chain command.
  always_comb begin
    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    id_nxt    = id_r;
    case (ctl.cmd)
      vtq_pkg::CMD_INS: begin
        valid_nxt = valid_r || left.valid;
        if (left.cond) begin
          dl_nxt = left.dl;
          id_nxt = left_id;
        end else if (cond) begin
          dl_nxt = ctl.new_dl;
          id_nxt = cmd_id;
        end
      end
      vtq_pkg::CMD_REM: begin
        if (found_out) begin
          valid_nxt = right.valid;
          dl_nxt    = right.dl;
          id_nxt    = right_id;
        end
      end
      vtq_pkg::CMD_POP: begin
        valid_nxt = right.valid;
        dl_nxt    = right.dl;
        id_nxt    = right_id;
      end
      vtq_pkg::CMD_SETT: begin
        dl_nxt = shifted_sat;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // Valid bit is control state and resets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    id_r <= id_nxt;
  end

endmodule

// ----- hdl/virtual_time_event_queue.sv -----
// Top level of the virtual time event queue: controller, clock and output register.
// Depends on vtq_pkg, vtq_cell and virtual_time_event_queue_defines.svh.
//
//  channel   direction  handshake               payload
//  in_       slave      in_tvalid / in_tready   in_tdata, in_tuser (opcode)
//  out_      master     out_tvalid / out_tready out_tdata, out_tuser (status), out_tlast
//  cfg_      slave      cfg_valid / cfg_ready   cfg_data (speed factor)
//
// Insert, remove and set time are accepted, then applied in the cell chain; an insert to
// a full queue yields a drop word. Set suspend acts at accept. A tick, unless suspended,
// forms its product at accept, adds it to the clock and pops due entries from the head.
// Reset clears every valid bit, virtual time and suspend flag, and sets speed to 1.0.
// A stalled output holds the pop loop; a new word is taken only in the idle state.
`include "virtual_time_event_queue_defines.svh"

module virtual_time_event_queue #(
  parameter int QUEUE_DEPTH = vtq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = vtq_pkg::DEF_ID_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input words.
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_id [7:0], delay [39:8], real_delta [71:40], new_time [119:72],
  // suspend_flag [120], zero fill [127:121]
  input  logic [127:0] in_tdata,
  // opcode [2:0]
  input  logic [2:0]   in_tuser,
  // Result words.
  output logic         out_tvalid,
  input  logic         out_tready,
  // due_id [7:0], lateness [39:8]
  output logic [39:0]  out_tdata,
  // status [0]
  output logic         out_tuser,
  output logic         out_tlast,
  // Speed factor writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int TW = vtq_pkg::TIME_W;
  localparam int LW = vtq_pkg::LATE_W;

  vtq_pkg::state_t            state_r, state_nxt;
  logic [vtq_pkg::SPEED_W-1:0] speed_r;
  logic [TW-1:0]              vt_r;
  logic                       susp_r;
  logic [ID_BITS-1:0]         item_id_r;
  logic [TW-1:0]              ins_dl_r;
  logic [TW:0]                diff_r;
  logic [TW-1:0]              prod_r;

  logic                       out_valid_r;
  logic [7:0]                 out_id_r;
  logic [LW-1:0]              out_late_r;
  logic                       out_stat_r;
  logic                       out_last_r;

  logic                       in_fire;
  vtq_pkg::op_t               op;
  logic [ID_BITS-1:0]         in_id;
  logic [31:0]                in_delay;
  logic [31:0]                in_rdelta;
  logic [TW-1:0]              in_ntime;
  logic                       in_sflag;
  logic [TW:0]                ins_sum;
  logic [TW:0]                tick_sum;
  logic [TW-1:0]              head_late;

  vtq_pkg::cell_ctl_t         ctl;
  vtq_pkg::cell_link_t        links [QUEUE_DEPTH];
  logic [ID_BITS-1:0]         ids   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]       found;
  logic [QUEUE_DEPTH-1:0]     due_vec;
  logic [QUEUE_DEPTH-1:0]     valid_vec;
  logic                       full;
  logic                       out_free;
  logic                       out_load;
  logic                       load_stat;
  logic                       load_last;

  // Input word unpacking.
  assign in_fire   = in_tvalid && in_tready;
  assign op        = vtq_pkg::op_t'(in_tuser);
  assign in_id     = ID_BITS'(in_tdata[7:0]);
  assign in_delay  = in_tdata[39:8];
  assign in_rdelta = in_tdata[71:40];
  assign in_ntime  = in_tdata[119:72];
  assign in_sflag  = in_tdata[120];

  assign in_tready = (state_r == vtq_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Saturating deadline of a new entry and advanced clock after a tick.
  assign ins_sum  = {1'b0, vt_r} + (TW + 1)'(in_delay);
  assign tick_sum = {1'b0, vt_r} + (TW + 1)'(prod_r[TW-1:8]);

  // Chain of slots.
  assign ctl.cmd    = vtq_pkg::CMD_HOLD;
  assign found[0]   = 1'b0;
  assign full       = links[QUEUE_DEPTH-1].valid;

  vtq_pkg::cell_cmd_t cmd;
  assign ctl.new_dl = ins_dl_r;
  assign ctl.vt     = vt_r;
  assign ctl.diff   = diff_r;

  vtq_pkg::cell_ctl_t ctl_bus;
  always_comb begin
    ctl_bus     = ctl;
    ctl_bus.cmd = cmd;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    vtq_pkg::cell_link_t lnk_l, lnk_r;
    logic [ID_BITS-1:0]  id_l, id_r;

    // Head cell sees a full, never-shifting left side; tail sees an empty right side.
    if (i == 0) begin : g_head
      assign lnk_l = '{valid: 1'b1, cond: 1'b0, dl: '0};
      assign id_l  = '0;
    end else begin : g_mid_l
      assign lnk_l = links[i-1];
      assign id_l  = ids[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign lnk_r = '{valid: 1'b0, cond: 1'b1, dl: links[i].dl};
      assign id_r  = ids[i];
    end else begin : g_mid_r
      assign lnk_r = links[i+1];
      assign id_r  = ids[i+1];
    end

    vtq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl_bus),
      .cmd_id    (item_id_r),
      .left      (lnk_l),
      .left_id   (id_l),
      .right     (lnk_r),
      .right_id  (id_r),
      .found_in  (found[i]),
      .self      (links[i]),
      .self_id   (ids[i]),
      .found_out (found[i+1]),
      .due       (due_vec[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // Lateness of the head entry, saturated to the output width.
  assign head_late = vt_r - links[0].dl;
  assign out_free  = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vtq_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (op)
            vtq_pkg::OP_INSERT:  state_nxt = full ? vtq_pkg::ST_DROP : vtq_pkg::ST_INS;
            vtq_pkg::OP_REMOVE:  state_nxt = vtq_pkg::ST_REM;
            vtq_pkg::OP_TICK:    state_nxt = susp_r ? vtq_pkg::ST_IDLE : vtq_pkg::ST_TADD;
            vtq_pkg::OP_SETTIME: state_nxt = vtq_pkg::ST_SETT;
            default:             state_nxt = vtq_pkg::ST_IDLE;
          endcase
        end
      end
      vtq_pkg::ST_INS, vtq_pkg::ST_REM, vtq_pkg::ST_SETT: begin
        state_nxt = vtq_pkg::ST_IDLE;
      end
      vtq_pkg::ST_TADD: begin
        state_nxt = vtq_pkg::ST_POP;
      end
      vtq_pkg::ST_POP: begin
        if (!due_vec[0] || (out_free && !due_vec[1])) begin
          state_nxt = vtq_pkg::ST_IDLE;
        end
      end
      vtq_pkg::ST_DROP: begin
        if (out_free) begin
          state_nxt = vtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vtq_pkg::ST_IDLE;
      end
    endcase
  end

  // Chain command and output register loads.
  always_comb begin
    cmd       = vtq_pkg::CMD_HOLD;
    out_load  = 1'b0;
    load_stat = vtq_pkg::STATUS_DUE;
    load_last = 1'b0;
    case (state_r)
      vtq_pkg::ST_INS:  cmd = vtq_pkg::CMD_INS;
      vtq_pkg::ST_REM:  cmd = vtq_pkg::CMD_REM;
      vtq_pkg::ST_SETT: cmd = vtq_pkg::CMD_SETT;
      vtq_pkg::ST_POP: begin
        if (due_vec[0] && out_free) begin
          cmd       = vtq_pkg::CMD_POP;
          out_load  = 1'b1;
          load_last = !due_vec[1];
        end
      end
      vtq_pkg::ST_DROP: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_stat = vtq_pkg::STATUS_DROP;
          load_last = 1'b1;
        end
      end
      default: begin
        cmd = vtq_pkg::CMD_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vtq_pkg::ST_IDLE;
      speed_r     <= vtq_pkg::SPEED_RESET;
      vt_r        <= '0;
      susp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        speed_r <= cfg_data;
      end
      if (in_fire && op == vtq_pkg::OP_SUSPEND) begin
        susp_r <= in_sflag;
      end
      if (in_fire && op == vtq_pkg::OP_SETTIME) begin
        vt_r <= in_ntime;
      end else if (state_r == vtq_pkg::ST_TADD) begin
        vt_r <= tick_sum[TW] ? vtq_pkg::TIME_MAX : tick_sum[TW-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_id_r <= in_id;
      ins_dl_r  <= ins_sum[TW] ? vtq_pkg::TIME_MAX : ins_sum[TW-1:0];
      diff_r    <= {1'b0, in_ntime} - {1'b0, vt_r};
      prod_r    <= in_rdelta * speed_r;
    end
    if (out_load) begin
      out_stat_r <= load_stat;
      out_last_r <= load_last;
      if (load_stat == vtq_pkg::STATUS_DROP) begin
        out_id_r   <= 8'(item_id_r);
        out_late_r <= '0;
      end else begin
        out_id_r   <= 8'(ids[0]);
        out_late_r <= (|head_late[TW-1:LW]) ? {LW{1'b1}} : head_late[LW-1:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_late_r, out_id_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // Occupied slots always form a prefix of the chain.
  `VTQ_ASSERT_IMP(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "valid gap in chain")
  // An insert grows the queue by exactly one entry.
  `VTQ_ASSERT_NXT(a_ins_grow, state_r == vtq_pkg::ST_INS, $countones(valid_vec) == $countones($past(valid_vec)) + 1, "insert did not add one entry")
  // Each emitted due entry leaves the queue.
  `VTQ_ASSERT_NXT(a_pop_shrink, out_load && load_stat == vtq_pkg::STATUS_DUE, $countones(valid_vec) + 1 == $countones($past(valid_vec)), "pop did not remove one entry")
  // A tick never moves virtual time backward.
  `VTQ_ASSERT_NXT(a_tick_mono, state_r == vtq_pkg::ST_TADD, vt_r >= $past(vt_r), "virtual time went backward")

endmodule
